FILE: rtl/core/zgg_pkg.sv
// Package for the ziggurat Gaussian generator: sizes, op codes, register
// indexes, the table entry type and the two LFSR step functions.
// No dependencies.
package zgg_pkg;

    localparam int TABLE_DEPTH    = 256;
    localparam int SHUFFLE_PERIOD = 32768;
    localparam int TRY_LIMIT      = 2 * (SHUFFLE_PERIOD + 1);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(SHUFFLE_PERIOD + 1);
    localparam int TRIES_W = $clog2(TRY_LIMIT + 1);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_GENERATE = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;

    localparam logic REG_SEED_A = 1'b0;
    localparam logic REG_SEED_B = 1'b1;

    localparam logic [15:0] SEED_A_RESET = 16'h3edf;
    localparam logic [15:0] SEED_B_RESET = 16'h5d79;
    localparam logic [7:0]  LAYER_MASK   = 8'hff;
    localparam int          SIGN_BIT     = 14;

    typedef struct packed {
        logic [15:0] layer_edge;
        logic [15:0] edge_ratio;
    } tbl_entry_t;

    // Layer-select LFSR, taps 0,2,3,5, shifting right.
    function automatic logic [15:0] step_a(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

    // Magnitude LFSR, taps 0,1,3,11, shifting right.
    function automatic logic [15:0] step_b(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[1] ^ v[3] ^ v[11];
        return {fb, v[15:1]};
    endfunction

endpackage

FILE: rtl/core/ziggurat_gaussian_generator.sv
// Ziggurat Gaussian generator top level: request decode, trial sequencer,
// layer table memory and output register. Depends on zgg_pkg.
//
// Each request is one op: op 1 writes a layer table entry, op 2 reloads both
// LFSRs from the seed registers, op 3 is ignored. Op 0 runs trials until one
// is accepted and then returns one signed Q3.13 sample. A trial whose layer
// draw is zero reads no table entry; any other trial reads the layer's edge
// and ratio from the table memory into a register before the ratio check.
// The ratio check registers the product, and an accepted trial then loads
// the output register from it once the output is free. If no trial is
// accepted within 65538 trials the request ends with no result. The table is
// not cleared at reset: every layer used must be written first.
module ziggurat_gaussian_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    // op[1:0], entry_index[9:2], layer_edge[25:10], edge_ratio[41:26]
    input  logic [zgg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample[16:0]
    output logic [zgg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [zgg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TRY   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_MUL   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [15:0] seed_a_reg, seed_b_reg;
    logic [15:0] lfsr_a_reg, lfsr_a_next;
    logic [15:0] lfsr_b_reg, lfsr_b_next;
    logic [zgg_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [zgg_pkg::TRIES_W-1:0] tries_reg, tries_next;
    logic [15:0] u_reg, u_next;
    logic        neg_reg, neg_next;
    logic [31:0] prod_reg, prod_next;
    logic        m_valid_reg, m_valid_next;
    logic [16:0] sample_reg, sample_next;

    // request fields
    logic [1:0]  in_op;
    logic [7:0]  in_index;
    logic [15:0] in_edge;
    logic [15:0] in_ratio;
    logic        in_fire;

    // table memory
    zgg_pkg::tbl_entry_t tbl_mem [zgg_pkg::TABLE_DEPTH];
    zgg_pkg::tbl_entry_t tbl_rdata_reg;
    logic                tbl_we, tbl_re;
    logic [zgg_pkg::IDX_W-1:0] tbl_waddr, tbl_raddr;

    // trial datapath
    logic [zgg_pkg::COUNT_W:0] count_inc;
    logic        do_shuffle;
    logic [15:0] a_mix, b_mix, a_new, b_new;
    logic [7:0]  layer;
    logic        layer_ok;
    logic        out_free;
    logic [15:0] mag;

    assign in_op    = s_axis_tdata[1:0];
    assign in_index = s_axis_tdata[9:2];
    assign in_edge  = s_axis_tdata[25:10];
    assign in_ratio = s_axis_tdata[41:26];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(zgg_pkg::OUT_DATA_W - 17){1'b0}}, sample_reg};

    // shuffle comes before the trial's LFSR steps
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign do_shuffle = (count_inc > (zgg_pkg::COUNT_W + 1)'(zgg_pkg::SHUFFLE_PERIOD));
    assign a_mix      = do_shuffle ? (lfsr_b_reg - lfsr_a_reg) : lfsr_a_reg;
    assign b_mix      = do_shuffle ? (lfsr_a_reg + lfsr_a_reg) : lfsr_b_reg;
    assign a_new      = zgg_pkg::step_a(a_mix);
    assign b_new      = zgg_pkg::step_b(b_mix);
    assign layer      = a_new[7:0] & zgg_pkg::LAYER_MASK;
    assign layer_ok   = (layer != 8'd0) && ({1'b0, layer} < 9'(zgg_pkg::TABLE_DEPTH));

    assign out_free = !m_valid_reg || m_axis_tready;
    assign mag      = prod_reg[31:16];

    assign tbl_we    = in_fire && (in_op == zgg_pkg::OP_WRITE)
                       && ({1'b0, in_index} < 9'(zgg_pkg::TABLE_DEPTH));
    assign tbl_waddr = in_index[zgg_pkg::IDX_W-1:0];
    assign tbl_re    = (state_reg == ST_TRY) && layer_ok;
    assign tbl_raddr = layer[zgg_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        lfsr_a_next  = lfsr_a_reg;
        lfsr_b_next  = lfsr_b_reg;
        count_next   = count_reg;
        tries_next   = tries_reg;
        u_next       = u_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        sample_next  = sample_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        zgg_pkg::OP_GENERATE:
                        begin
                            tries_next = '0;
                            state_next = ST_TRY;
                        end
                        zgg_pkg::OP_RESTART:
                        begin
                            lfsr_a_next = seed_a_reg;
                            lfsr_b_next = seed_b_reg;
                            count_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRY:
            begin
                count_next  = do_shuffle ? '0 : count_inc[zgg_pkg::COUNT_W-1:0];
                lfsr_a_next = a_new;
                tries_next  = tries_reg + 1'b1;
                if (layer_ok)
                begin
                    lfsr_b_next = b_new;
                    u_next      = b_new;
                    neg_next    = a_new[zgg_pkg::SIGN_BIT];
                    state_next  = ST_CHECK;
                end
                else
                begin
                    lfsr_b_next = b_mix;
                    if (tries_next == zgg_pkg::TRIES_W'(zgg_pkg::TRY_LIMIT))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (u_reg < tbl_rdata_reg.edge_ratio)
                begin
                    prod_next  = 32'(tbl_rdata_reg.layer_edge) * 32'(u_reg);
                    state_next = ST_MUL;
                end
                else if (tries_reg == zgg_pkg::TRIES_W'(zgg_pkg::TRY_LIMIT))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_TRY;
                end
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    sample_next  = neg_reg ? (17'd0 - {1'b0, mag}) : {1'b0, mag};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seed_a_reg  <= zgg_pkg::SEED_A_RESET;
            seed_b_reg  <= zgg_pkg::SEED_B_RESET;
            lfsr_a_reg  <= zgg_pkg::SEED_A_RESET;
            lfsr_b_reg  <= zgg_pkg::SEED_B_RESET;
            count_reg   <= '0;
            tries_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lfsr_a_reg  <= lfsr_a_next;
            lfsr_b_reg  <= lfsr_b_next;
            count_reg   <= count_next;
            tries_reg   <= tries_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_index == zgg_pkg::REG_SEED_A))
            begin
                seed_a_reg <= cfg_data;
            end
            if (cfg_wr_en && (cfg_index == zgg_pkg::REG_SEED_B))
            begin
                seed_b_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        sample_reg <= sample_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= '{layer_edge: in_edge, edge_ratio: in_ratio};
        end
        if (tbl_re)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    // a generate request always starts a trial
    a_gen_starts_trial: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_op == zgg_pkg::OP_GENERATE)) |=> (state_reg == ST_TRY))
        else $error("generate request did not start a trial");

    // table data is checked in the cycle right after its read
    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_re |=> (state_reg == ST_CHECK))
        else $error("table read not followed by ratio check");

    // a result only appears after the multiply stage
    a_result_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_MUL))
        else $error("result loaded outside multiply stage");

    // trial and shuffle counters stay in range
    a_counters_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tries_reg <= zgg_pkg::TRIES_W'(zgg_pkg::TRY_LIMIT))
        && (count_reg <= zgg_pkg::COUNT_W'(zgg_pkg::SHUFFLE_PERIOD)))
        else $error("trial or shuffle counter out of range");

endmodule

FILE: tb/tb.sv
// Self-checking bench for ziggurat_gaussian_generator: a clocked driver and monitor
// around the stream ports, with an in-bench predictor of the LFSR trial loop.
// Depends on zgg_pkg and the generator top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zgg_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_REQS  = 1024;
    localparam int          CHUNKS       = 4;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [15:0] SEL_TAPS     = 16'h002d;  // bits 0,2,3,5
    localparam logic [15:0] MAG_TAPS     = 16'h080b;  // bits 0,1,3,11

    // lowest bits first: op, entry_index, layer_edge, edge_ratio
    typedef struct packed {
        logic [15:0] edge_ratio;
        logic [15:0] layer_edge;
        logic [7:0]  entry_index;
        logic [1:0]  op;
    } zgg_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_wr_en;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ziggurat_gaussian_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [15:0] seed_a_val = SEED_A_RESET;
    logic [15:0] seed_b_val = SEED_B_RESET;
    logic [15:0] sel_lfsr   = SEED_A_RESET;
    logic [15:0] mag_lfsr   = SEED_B_RESET;
    int unsigned trial_count = 0;
    logic [15:0] layer_edge_mem  [TABLE_DEPTH];
    logic [15:0] layer_ratio_mem [TABLE_DEPTH];
    bit          draw_gave_up = 1'b0;

    zgg_req_t    req_q[$];
    logic [16:0] sample_q[$];
    int          reqs_outstanding = 0;
    int          reqs_accepted    = 0;
    int          samples_checked  = 0;
    int          silent_draws     = 0;
    int          mismatches       = 0;
    int          cycles           = 0;
    bit          idle_on          = 1'b1;
    logic        req_taken        = 1'b0;

    // One generate request: run trials until a layer accepts or the limit is hit.
    function automatic bit draw_sample(output logic [16:0] s);
        logic [15:0] a;
        logic [15:0] u;
        logic [15:0] prev_a;
        logic [31:0] prod;
        logic [16:0] mag;
        int          t;
        s = '0;
        for (t = 0; t < TRY_LIMIT; t++)
        begin
            // mix comes before this trial's steps
            if (trial_count >= SHUFFLE_PERIOD)
            begin
                prev_a      = sel_lfsr;
                sel_lfsr    = mag_lfsr - prev_a;
                mag_lfsr    = prev_a + prev_a;
                trial_count = 0;
            end
            else
                trial_count++;
            sel_lfsr = {^(sel_lfsr & SEL_TAPS), sel_lfsr[15:1]};
            a = sel_lfsr;
            if (a[7:0] == 8'd0)
                continue;
            mag_lfsr = {^(mag_lfsr & MAG_TAPS), mag_lfsr[15:1]};
            u = mag_lfsr;
            if (u < layer_ratio_mem[a[7:0]])
            begin
                prod = {16'd0, layer_edge_mem[a[7:0]]} * {16'd0, u};
                mag  = {1'b0, prod[31:16]};
                s    = a[SIGN_BIT] ? -mag : mag;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void take_request(input zgg_req_t r);
        logic [16:0] s;
        case (r.op)
            OP_WRITE:
            begin
                layer_edge_mem[r.entry_index]  = r.layer_edge;
                layer_ratio_mem[r.entry_index] = r.edge_ratio;
            end
            OP_RESTART:
            begin
                sel_lfsr    = seed_a_val;
                mag_lfsr    = seed_b_val;
                trial_count = 0;
            end
            OP_GENERATE:
            begin
                if (draw_sample(s))
                begin
                    sample_q.push_back(s);
                    draw_gave_up = 1'b0;
                end
                else
                begin
                    draw_gave_up = 1'b1;
                    silent_draws++;
                end
            end
            default: ;
        endcase
    endfunction

    // request driver
    always @(negedge clk)
    begin : req_driver
        int gap_left;
        if (rst_n)
        begin
            if (!s_axis_tvalid || req_taken)
            begin
                if (idle_on && gap_left == 0 && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 8);
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    s_axis_tdata  <= {{(IN_DATA_W - $bits(zgg_req_t)){1'b0}}, req_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
        else
            gap_left = 0;
    end

    // result back-pressure
    always @(negedge clk)
    begin : sample_sink
        int stall_left;
        if (rst_n)
        begin
            if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
        else
            stall_left = 0;
    end

    // monitor: predict on each accepted request, check each accepted sample
    always @(posedge clk)
    begin : monitor
        logic [16:0] want;
        logic [16:0] got;
        if (rst_n)
        begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_request(zgg_req_t'(s_axis_tdata[$bits(zgg_req_t)-1:0]));
                reqs_outstanding--;
                reqs_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[16:0];
                if (sample_q.size() == 0)
                begin
                    $error("sample: none expected, got %0d", $signed(got));
                    mismatches++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    samples_checked++;
                    if (got !== want)
                    begin
                        $error("sample: expected %0d, got %0d", $signed(want), $signed(got));
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] op, input logic [7:0] idx,
                             input logic [15:0] le, input logic [15:0] er);
        zgg_req_t r;
        r.op          = op;
        r.entry_index = idx;
        r.layer_edge  = le;
        r.edge_ratio  = er;
        req_q.push_back(r);
        reqs_outstanding++;
    endtask

    task automatic queue_draws(input int n);
        repeat (n) queue_req(OP_GENERATE, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // writes every layer; a few edges and ratios sit at their extremes, or every ratio is zero if ratios_zero
    task automatic fill_table(input bit ratios_zero);
        int          i;
        logic [15:0] le;
        logic [15:0] er;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            le = (i % 16 == 1) ? 16'h0000 : (i % 16 == 2) ? 16'hffff : 16'($urandom);
            if (ratios_zero || i % 23 == 5)
                er = 16'h0000;
            else if (i % 19 == 3)
                er = 16'hffff;
            else
                er = 16'($urandom_range(1, 65535));
            queue_req(OP_WRITE, 8'(i), le, er);
        end
    endtask

    task automatic queue_random_req(output bit ignored);
        int unsigned pick;
        logic [1:0]  op;
        logic [15:0] le;
        logic [15:0] er;
        pick = $urandom_range(0, 99);
        op = (pick < 70) ? OP_GENERATE : (pick < 85) ? OP_WRITE :
             (pick < 93) ? OP_RESTART : OP_UNUSED;
        le = 16'($urandom);
        er = 16'($urandom);
        if (op == OP_WRITE)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                er = 16'h0000;
            else if (pick == 1)
                er = 16'hffff;
            else if (pick == 2)
                le = 16'h0000;
            else if (pick == 3)
                le = 16'hffff;
        end
        queue_req(op, 8'($urandom), le, er);
        ignored = (op == OP_UNUSED);
    endtask

    // Let every request go in and every sample come out; a draw that ran
    // out of trials leaves nothing to wait on, so allow its full length.
    task automatic drain();
        while (reqs_outstanding != 0 || sample_q.size() != 0)
            @(negedge clk);
        repeat (draw_gave_up ? 2 * TRY_LIMIT + 100 : 40) @(negedge clk);
    endtask

    task automatic write_seed(input logic idx, input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SEED_A)
            seed_a_val = v;
        else
            seed_b_val = v;
    endtask

    initial
    begin : stimulus
        int k;
        int counted;
        bit ignored;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SEED_A;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // table must be complete before the first draw
        fill_table(1'b0);
        queue_draws(6);
        queue_req(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
        queue_draws(2);
        queue_req(OP_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
        queue_draws(4);
        queue_req(OP_WRITE, 8'd0, 16'hffff, 16'hffff);
        queue_req(OP_WRITE, 8'd255, 16'h0000, 16'hffff);
        queue_req(OP_WRITE, 8'd128, 16'hffff, 16'h0000);
        queue_draws(6);
        drain();

        // zero A seed: layer zero until the first mix, then B is stuck at zero
        write_seed(REG_SEED_A, 16'h0000);
        write_seed(REG_SEED_B, 16'hffff);
        queue_req(OP_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
        queue_draws(3);
        drain();

        // all ratios zero: the draw runs out of trials after two mixes,
        // and later samples carry the mixed LFSR state
        write_seed(REG_SEED_A, 16'hffff);
        write_seed(REG_SEED_B, 16'h0001);
        fill_table(1'b1);
        queue_req(OP_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
        queue_draws(1);
        fill_table(1'b0);
        queue_draws(5);
        drain();

        for (k = 0; k < CHUNKS; k++)
        begin
            if (k == 1)
            begin
                write_seed(REG_SEED_A, 16'h0001);
                write_seed(REG_SEED_B, 16'hffff);
            end
            else
            begin
                write_seed(REG_SEED_A, 16'($urandom_range(1, 65535)));
                write_seed(REG_SEED_B, 16'($urandom_range(1, 65535)));
            end
            idle_on = (k != CHUNKS - 1);
            queue_req(OP_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
            counted = 0;
            while (counted < RANDOM_REQS / CHUNKS)
            begin
                queue_random_req(ignored);
                if (!ignored)
                    counted++;
            end
            drain();
        end

        $display("tb: %0d requests over %0d seed settings, %0d samples checked",
                 reqs_accepted, CHUNKS + 3, samples_checked);
        $display("tb: %0d draws ran out of trials", silent_draws);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/zgg_pkg.sv
rtl/core/ziggurat_gaussian_generator.sv
tb/tb.sv
